[rtl/circular_stack_swap_rotate_defines.svh]
// assertion macros shared by the circular stack rtl
`ifndef CIRCULAR_STACK_SWAP_ROTATE_DEFINES_SVH
`define CIRCULAR_STACK_SWAP_ROTATE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CSSR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define CSSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/cssr_pkg.sv]
// types, codes and ring arithmetic for the circular stack
package cssr_pkg;

    localparam int DEPTH  = 512;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [DATA_W-1:0] data_t;

    localparam logic [2:0] REQ_PUSH = 3'd0;
    localparam logic [2:0] REQ_POP  = 3'd1;
    localparam logic [2:0] REQ_SWAP = 3'd2;
    localparam logic [2:0] REQ_ROT  = 3'd3;
    localparam logic [2:0] REQ_RROT = 3'd4;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_SMALL = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0] status;
        logic       rd_en;
        logic       wr_en;
        ptr_t       acc_addr;
        logic       fill_wr;
        ptr_t       fill_addr;
        logic       pop;
        logic       load_top;
        ptr_t       next_top;
        cnt_t       next_count;
    } plan_t;

    // (p + off) mod DEPTH, with off no larger than DEPTH
    function automatic ptr_t ring_add(input ptr_t p, input cnt_t off);
        logic [PTR_W:0] sum;
        sum = {1'b0, p} + (PTR_W + 1)'(off);
        if (sum >= (PTR_W + 1)'(DEPTH))
        begin
            sum = sum - (PTR_W + 1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    function automatic ptr_t ring_dec(input ptr_t p);
        ptr_t r;
        if (p == '0)
        begin
            r = PTR_W'(DEPTH - 1);
        end
        else
        begin
            r = p - PTR_W'(1);
        end
        return r;
    endfunction

endpackage

[rtl/cssr_plan.sv]
// request decode: status, store addresses and new pointer and count
module cssr_plan (
    input  logic [2:0]           req_type,
    input  cssr_pkg::ptr_t       top,
    input  cssr_pkg::cnt_t       count,
    output cssr_pkg::plan_t      plan
);

    logic two_or_more;
    logic full;

    assign two_or_more = count > cssr_pkg::CNT_W'(1);
    assign full        = count >= cssr_pkg::CNT_W'(cssr_pkg::DEPTH);

    always_comb
    begin
        plan            = '0;
        plan.status     = cssr_pkg::ST_SMALL;
        plan.acc_addr   = top;
        plan.fill_addr  = top;
        plan.next_top   = top;
        plan.next_count = count;
        unique case (req_type)
            cssr_pkg::REQ_PUSH:
            begin
                if (full)
                begin
                    plan.status = cssr_pkg::ST_FULL;
                end
                else
                begin
                    // the old top leaves the register for its own slot
                    plan.status     = cssr_pkg::ST_DONE;
                    plan.wr_en      = count != '0;
                    plan.load_top   = 1'b1;
                    plan.next_top   = cssr_pkg::ring_dec(top);
                    plan.next_count = count + cssr_pkg::CNT_W'(1);
                end
            end
            cssr_pkg::REQ_POP:
            begin
                if (count != '0)
                begin
                    plan.status     = cssr_pkg::ST_DONE;
                    plan.rd_en      = 1'b1;
                    plan.pop        = 1'b1;
                    plan.acc_addr   = cssr_pkg::ring_add(top, cssr_pkg::CNT_W'(1));
                    plan.next_top   = cssr_pkg::ring_add(top, cssr_pkg::CNT_W'(1));
                    plan.next_count = count - cssr_pkg::CNT_W'(1);
                end
            end
            cssr_pkg::REQ_SWAP:
            begin
                if (two_or_more)
                begin
                    plan.status    = cssr_pkg::ST_DONE;
                    plan.rd_en     = 1'b1;
                    plan.fill_wr   = 1'b1;
                    plan.acc_addr  = cssr_pkg::ring_add(top, cssr_pkg::CNT_W'(1));
                    plan.fill_addr = cssr_pkg::ring_add(top, cssr_pkg::CNT_W'(1));
                end
            end
            cssr_pkg::REQ_ROT:
            begin
                if (two_or_more)
                begin
                    // when full the slot past the bottom is the top slot itself
                    plan.status    = cssr_pkg::ST_DONE;
                    plan.rd_en     = 1'b1;
                    plan.fill_wr   = 1'b1;
                    plan.acc_addr  = cssr_pkg::ring_add(top, cssr_pkg::CNT_W'(1));
                    plan.fill_addr = cssr_pkg::ring_add(top, count);
                    plan.next_top  = cssr_pkg::ring_add(top, cssr_pkg::CNT_W'(1));
                end
            end
            cssr_pkg::REQ_RROT:
            begin
                if (two_or_more)
                begin
                    plan.status    = cssr_pkg::ST_DONE;
                    plan.rd_en     = 1'b1;
                    plan.fill_wr   = 1'b1;
                    plan.acc_addr  = cssr_pkg::ring_add(top, count - cssr_pkg::CNT_W'(1));
                    plan.fill_addr = top;
                    plan.next_top  = cssr_pkg::ring_dec(top);
                end
            end
            default:
            begin
                plan.status = cssr_pkg::ST_SMALL;
            end
        endcase
    end

endmodule

[rtl/circular_stack_swap_rotate.sv]
// push, failed requests: result in the cycle after acceptance, next request the following cycle
// pop, swap, rotate, reverse rotate: read on acceptance, then busy in a write-back state, result
// registered as it ends; no new request is taken while busy, as the single-port store must read, then write back
// the top entry lives in a register; the others sit in the store at their ring positions
// reset clears the top pointer, the count and the result strobe at once;
// store contents are undefined and never cleared, so requests are taken straight after reset
module circular_stack_swap_rotate (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          req_type,
    input  logic signed [31:0]  push_value,
    output logic                done,
    output logic [1:0]          status,
    output logic signed [31:0]  popped_value,
    output logic [9:0]          stack_size
);

`include "circular_stack_swap_rotate_defines.svh"

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_FILL = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    cssr_pkg::ptr_t       top_reg;
    cssr_pkg::cnt_t       count_reg;
    cssr_pkg::data_t      top_val_reg;
    cssr_pkg::plan_t      plan;
    logic                 accept;

    logic                 fill_wr_reg;
    cssr_pkg::ptr_t       fill_addr_reg;
    logic                 pop_reg;
    logic [1:0]           fill_status_reg;

    logic                 done_reg;
    logic [1:0]           status_reg;
    cssr_pkg::data_t      popped_reg;
    cssr_pkg::cnt_t       size_reg;

    logic                 mem_we;
    cssr_pkg::ptr_t       mem_addr;
    cssr_pkg::data_t      mem_wdata;
    cssr_pkg::data_t      mem_rdata;
    cssr_pkg::data_t      mem [cssr_pkg::DEPTH];

    cssr_plan u_plan (
        .req_type (req_type),
        .top      (top_reg),
        .count    (count_reg),
        .plan     (plan)
    );

    assign busy   = state_reg == S_FILL;
    assign accept = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && plan.rd_en)
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // one store access a cycle: spill on push, read on accept, write back in fill
    always_comb
    begin
        mem_wdata = top_val_reg;
        if (state_reg == S_FILL)
        begin
            mem_we   = fill_wr_reg;
            mem_addr = fill_addr_reg;
        end
        else
        begin
            mem_we   = accept && plan.wr_en;
            mem_addr = plan.acc_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        else
        begin
            mem_rdata <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            top_reg   <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (accept && !plan.rd_en) || (state_reg == S_FILL);
            if (accept)
            begin
                top_reg   <= plan.next_top;
                count_reg <= plan.next_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fill_wr_reg     <= plan.fill_wr;
            fill_addr_reg   <= plan.fill_addr;
            pop_reg         <= plan.pop;
            fill_status_reg <= plan.status;
            if (plan.load_top)
            begin
                top_val_reg <= push_value;
            end
            if (!plan.rd_en)
            begin
                status_reg <= plan.status;
                popped_reg <= '0;
                size_reg   <= plan.next_count;
            end
        end
        else if (state_reg == S_FILL)
        begin
            // the old top goes out before the fetched entry replaces it
            top_val_reg <= mem_rdata;
            status_reg  <= fill_status_reg;
            popped_reg  <= pop_reg ? top_val_reg : '0;
            size_reg    <= count_reg;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign popped_value = popped_reg;
    assign stack_size   = size_reg;

    `CSSR_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= cssr_pkg::CNT_W'(cssr_pkg::DEPTH),
        "entry count beyond store depth")
    `CSSR_ASSERT_NEXT(a_read_goes_busy, accept && plan.rd_en, busy && !done,
        "request needing a store read did not hold busy")
    `CSSR_ASSERT_NEXT(a_fill_ends, state_reg == S_FILL, state_reg == S_IDLE && done,
        "write-back cycle did not finish with a result")
    `CSSR_ASSERT_NOW(a_popped_only_on_pop, done && popped_value != '0,
        status == cssr_pkg::ST_DONE, "popped value reported without a successful pop")

endmodule
